FILE: rtl/mkv_pkg.sv
package mkv_pkg;

    typedef struct packed {
        logic        req_type;
        logic [63:0] hash_word0;
        logic [63:0] hash_word1;
        logic [63:0] hash_word2;
        logic [63:0] hash_word3;
        logic [63:0] position;
        logic [63:0] leaf_count;
        logic        final_item;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] built_word0;
        logic [63:0] built_word1;
        logic [63:0] built_word2;
        logic [63:0] built_word3;
    } out_item_t;

    localparam logic       REQ_START   = 1'b0;
    localparam logic       REQ_SIBLING = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISMATCH = 3'd1;
    localparam logic [2:0] ST_BAD_IDX  = 3'd2;
    localparam logic [2:0] ST_BAD_LEN  = 3'd3;
    localparam logic [2:0] ST_NO_START = 3'd4;

    localparam logic [1:0] CFG_ROOT0 = 2'd0;
    localparam logic [1:0] CFG_ROOT1 = 2'd1;
    localparam logic [1:0] CFG_ROOT2 = 2'd2;
    localparam logic [1:0] CFG_ROOT3 = 2'd3;

    localparam logic [7:0] NODE_PREFIX = 8'h01;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SKIP,
        S_HASH,
        S_REPORT
    } state_t;

    // Hash engine control toward the compression unit.
    typedef struct packed {
        logic         start;
        logic [511:0] block0;
        logic [511:0] block1;
    } sha_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sha_sts_t;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    localparam logic [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

endpackage

FILE: rtl/mkv_sha_core.sv
// Two-block SHA-256 compression, one round per cycle.
module mkv_sha_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  mkv_pkg::sha_ctl_t ctl,
    output mkv_pkg::sha_sts_t sts,
    output logic [255:0]      digest
);

    logic [255:0] h_reg, h_next;
    logic [255:0] v_reg, v_next;
    logic [511:0] w_reg, w_next;
    logic [511:0] blk1_reg, blk1_next;
    logic [5:0]   round_reg, round_next;
    logic         second_reg, second_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;

    logic [31:0] a, b, c, d, e, f, g, hh;
    logic [31:0] w_cur, w_new, x15, x2, x7, x16;
    logic [31:0] ss0, ss1, bs0, bs1, ch, mj, t1, t2;
    logic [255:0] h_sum;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Round logic over the working variables and the rolling schedule window
    always_comb
    begin
        {a, b, c, d, e, f, g, hh} = v_reg;
        x16 = w_reg[511:480];
        x15 = w_reg[479:448];
        x7  = w_reg[223:192];
        x2  = w_reg[63:32];
        ss0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
        ss1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
        w_new = x16 + ss0 + x7 + ss1;
        w_cur = x16;
        bs1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
        ch  = (e & f) ^ (~e & g);
        t1  = hh + bs1 + ch + mkv_pkg::round_k(round_reg) + w_cur;
        bs0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
        mj  = (a & b) ^ (a & c) ^ (b & c);
        t2  = bs0 + mj;
        for (int i = 0; i < 8; i++)
        begin
            h_sum[i*32 +: 32] = h_reg[i*32 +: 32] + v_reg[i*32 +: 32];
        end
    end

    // Sequence rounds and blocks
    always_comb
    begin
        h_next      = h_reg;
        v_next      = v_reg;
        w_next      = w_reg;
        blk1_next   = blk1_reg;
        round_next  = round_reg;
        second_next = second_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (ctl.start && !busy_reg)
        begin
            h_next      = mkv_pkg::SHA_IV;
            v_next      = mkv_pkg::SHA_IV;
            w_next      = ctl.block0;
            blk1_next   = ctl.block1;
            round_next  = 6'd0;
            second_next = 1'b0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            v_next = {t1 + t2, a, b, c, d + t1, e, f, g};
            w_next = {w_reg[479:0], w_new};
            round_next = round_reg + 6'd1;
            if (round_reg == 6'd63)
            begin
                // Close this block; after the first block, start the second one
                h_next = {h_sum[255:224] + 32'h0, h_sum[223:0]};
                h_next[255:224] = h_reg[255:224] + t1 + t2;
                h_next[223:192] = h_reg[223:192] + a;
                h_next[191:160] = h_reg[191:160] + b;
                h_next[159:128] = h_reg[159:128] + c;
                h_next[127:96]  = h_reg[127:96] + d + t1;
                h_next[95:64]   = h_reg[95:64] + e;
                h_next[63:32]   = h_reg[63:32] + f;
                h_next[31:0]    = h_reg[31:0] + g;
                v_next = h_next;
                w_next = blk1_reg;
                if (second_reg)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                second_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg      <= h_next;
        v_reg      <= v_next;
        w_reg      <= w_next;
        blk1_reg   <= blk1_next;
        round_reg  <= round_next;
        second_reg <= second_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign digest   = h_reg;

endmodule

FILE: rtl/merkle_inclusion_verifier_unit.sv
// Merkle inclusion proof checker (RFC 6962 tree, SHA-256 interior nodes).
// Input channel in_valid/in_ready carries one transaction per audit step:
// a start (leaf hash, index, tree size) or a sibling hash; final_item marks
// the last one. The output channel out_valid/out_ready returns one result
// (status and rebuilt root) for each final transaction and for a sibling
// that arrives with no verification open.
// Configuration channel cfg_valid/cfg_ready writes the expected root words
// by index 0..3; write only while the block is idle.
// A start or an unhashed sibling leaves the block in idle; a final one
// passes through the report state before out_valid rises, and a sibling
// with no open verification raises out_valid at the accepting edge. A hashed
// sibling runs two 64-round compressions on the single round unit; when the
// core's registered done arrives, the digest is latched into the running hash
// and a non-final sibling returns to idle, a final one to the report state.
// The trailing-zero skip shifts one bit per cycle alongside the hash and ends
// before the hash completes. The result register holds until taken; a stalled
// receiver blocks the next transaction until the result leaves.
// Reset clears the proof state, the root registers and the output valid.
module merkle_inclusion_verifier_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mkv_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output mkv_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    mkv_pkg::state_t state_reg, state_next;
    logic [255:0] root_reg, root_next;
    logic [255:0] run_reg, run_next;
    logic [63:0]  idx_reg, idx_next;
    logic [63:0]  last_reg, last_next;
    logic         prog_reg, prog_next;
    logic [2:0]   fault_reg, fault_next;
    logic         fin_reg, fin_next;
    logic         ov_reg, ov_next;
    mkv_pkg::out_item_t od_reg, od_next;

    mkv_pkg::sha_ctl_t sha_ctl;
    mkv_pkg::sha_sts_t sha_sts;
    logic [255:0] digest;
    logic [255:0] in_hash;
    logic         accept;
    logic         hash_left_sib;

    assign in_hash   = {in_data.hash_word0, in_data.hash_word1,
                        in_data.hash_word2, in_data.hash_word3};
    assign in_ready  = (state_reg == mkv_pkg::S_IDLE) && !ov_reg;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign hash_left_sib = idx_reg[0] || (idx_reg == last_reg);

    mkv_sha_core u_sha
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (sha_ctl),
        .sts    (sha_sts),
        .digest (digest)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mkv_pkg::S_IDLE:
            begin
                if (accept && in_data.req_type == mkv_pkg::REQ_SIBLING && prog_reg
                    && fault_reg == mkv_pkg::ST_OK && last_reg != 64'd0)
                begin
                    state_next = hash_left_sib ? mkv_pkg::S_SKIP : mkv_pkg::S_HASH;
                end
                else if (accept && in_data.final_item
                         && !(in_data.req_type == mkv_pkg::REQ_SIBLING && !prog_reg))
                begin
                    state_next = mkv_pkg::S_REPORT;
                end
            end
            mkv_pkg::S_SKIP:
            begin
                if (!(idx_reg[0] == 1'b0 && idx_reg != 64'd0))
                begin
                    state_next = mkv_pkg::S_HASH;
                end
            end
            mkv_pkg::S_HASH:
            begin
                if (sha_sts.done)
                begin
                    state_next = fin_reg ? mkv_pkg::S_REPORT : mkv_pkg::S_IDLE;
                end
            end
            mkv_pkg::S_REPORT:
            begin
                state_next = mkv_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mkv_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        root_next  = root_reg;
        run_next   = run_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        prog_next  = prog_reg;
        fault_next = fault_reg;
        fin_next   = fin_reg;
        ov_next    = ov_reg && !out_ready;
        od_next    = od_reg;
        sha_ctl.start  = 1'b0;
        sha_ctl.block0 = {mkv_pkg::NODE_PREFIX, run_reg, in_hash[255:8]};
        sha_ctl.block1 = {in_hash[7:0], 8'h80, 480'd0, 16'h0208};

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mkv_pkg::CFG_ROOT0: root_next[255:192] = cfg_data;
                mkv_pkg::CFG_ROOT1: root_next[191:128] = cfg_data;
                mkv_pkg::CFG_ROOT2: root_next[127:64]  = cfg_data;
                mkv_pkg::CFG_ROOT3: root_next[63:0]    = cfg_data;
                default: root_next = root_reg;
            endcase
        end

        case (state_reg)
            mkv_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    fin_next = in_data.final_item;
                    if (in_data.req_type == mkv_pkg::REQ_START)
                    begin
                        run_next  = in_hash;
                        idx_next  = in_data.position;
                        prog_next = 1'b1;
                        if (in_data.leaf_count == 64'd0
                            || in_data.position >= in_data.leaf_count)
                        begin
                            fault_next = mkv_pkg::ST_BAD_IDX;
                            last_next  = 64'd0;
                        end
                        else
                        begin
                            fault_next = mkv_pkg::ST_OK;
                            last_next  = in_data.leaf_count - 64'd1;
                        end
                    end
                    else if (!prog_reg)
                    begin
                        // Stray sibling: answer at once
                        ov_next = 1'b1;
                        od_next = '0;
                        od_next.status = mkv_pkg::ST_NO_START;
                    end
                    else if (fault_reg == mkv_pkg::ST_OK)
                    begin
                        if (last_reg == 64'd0)
                        begin
                            fault_next = mkv_pkg::ST_BAD_LEN;
                        end
                        else
                        begin
                            // Start the hash with the sibling placed left or right in the block
                            sha_ctl.start = 1'b1;
                            if (hash_left_sib)
                            begin
                                sha_ctl.block0 = {mkv_pkg::NODE_PREFIX, in_hash,
                                                  run_reg[255:8]};
                                sha_ctl.block1 = {run_reg[7:0], 8'h80, 480'd0, 16'h0208};
                            end
                            else
                            begin
                                idx_next  = idx_reg >> 1;
                                last_next = last_reg >> 1;
                            end
                        end
                    end
                end
            end
            mkv_pkg::S_SKIP:
            begin
                // Shift one bit per cycle, then drop the final bit
                idx_next  = idx_reg >> 1;
                last_next = last_reg >> 1;
            end
            mkv_pkg::S_HASH:
            begin
                if (sha_sts.done)
                begin
                    run_next = digest;
                end
            end
            mkv_pkg::S_REPORT:
            begin
                ov_next = 1'b1;
                od_next.built_word0 = run_reg[255:192];
                od_next.built_word1 = run_reg[191:128];
                od_next.built_word2 = run_reg[127:64];
                od_next.built_word3 = run_reg[63:0];
                if (fault_reg != mkv_pkg::ST_OK)
                    od_next.status = fault_reg;
                else if (last_reg != 64'd0)
                    od_next.status = mkv_pkg::ST_BAD_LEN;
                else if (run_reg != root_reg)
                    od_next.status = mkv_pkg::ST_MISMATCH;
                else
                    od_next.status = mkv_pkg::ST_OK;
                prog_next = 1'b0;
            end
            default:
            begin
                ov_next = ov_reg && !out_ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mkv_pkg::S_IDLE;
            root_reg  <= '0;
            run_reg   <= '0;
            idx_reg   <= '0;
            last_reg  <= '0;
            prog_reg  <= 1'b0;
            fault_reg <= mkv_pkg::ST_OK;
            fin_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            root_reg  <= root_next;
            run_reg   <= run_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
            prog_reg  <= prog_next;
            fault_reg <= fault_next;
            fin_reg   <= fin_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    // A result is never produced while the hash unit is still running
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !sha_sts.busy)
        else $error("result while hashing");

    // Hash completion only happens in the hashing state
    assert property (@(posedge clk) disable iff (!rst_n)
        sha_sts.done |-> state_reg == mkv_pkg::S_HASH)
        else $error("stray hash completion");

    // A waiting result stays valid until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    mkv_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    mkv_pkg::out_item_t out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [63:0]        cfg_data;

    merkle_inclusion_verifier_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    localparam int IDLE_PCT   = 14;
    localparam int SETTLE_CYC = 260;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [255:0] H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    typedef struct {
        logic [255:0] acc;
        logic [63:0]  idx;
        logic [63:0]  last;
        bit           open;
        logic [2:0]   fault;
    } proof_state_t;

    typedef struct {
        mkv_pkg::in_item_t  item;
        bit                 typed;
        mkv_pkg::out_item_t result;
    } stim_row_t;

    proof_state_t       proof;
    logic [255:0]       root_reg;
    mkv_pkg::out_item_t pending_results[$];
    int                 error_count;
    int                 items_sent;
    bit                 calm;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [255:0] sha_block(input logic [255:0] hin,
                                               input logic [511:0] blk);
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] a, b, s0, s1, ch, mj, t1, t2, wt;
        logic [255:0] hout;
        for (int t = 0; t < 16; t++)
            w[t] = blk[511 - 32 * t -: 32];
        for (int t = 0; t < 8; t++)
            v[t] = hin[255 - 32 * t -: 32];
        for (int t = 0; t < 64; t++)
        begin
            if (t < 16)
                wt = w[t];
            else
            begin
                a  = w[(t - 15) & 15];
                b  = w[(t - 2) & 15];
                s0 = rotr(a, 7) ^ rotr(a, 18) ^ (a >> 3);
                s1 = rotr(b, 17) ^ rotr(b, 19) ^ (b >> 10);
                wt = w[t & 15] + s0 + w[(t - 7) & 15] + s1;
                w[t & 15] = wt;
            end
            s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
            ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1 = v[7] + s1 + ch + SHA_K[t] + wt;
            s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
            mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2 = s0 + mj;
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++)
            hout[255 - 32 * t -: 32] = hin[255 - 32 * t -: 32] + v[t];
        return hout;
    endfunction

    // Interior node: SHA-256 over prefix, left, right (65 bytes, two blocks)
    function automatic logic [255:0] interior_node(input logic [255:0] left,
                                                   input logic [255:0] right);
        logic [1023:0] msg;
        msg = {mkv_pkg::NODE_PREFIX, left, right, 8'h80, 480'd0, 16'h0208};
        return sha_block(sha_block(H_INIT, msg[1023:512]), msg[511:0]);
    endfunction

    // Advance the proof state by one transaction; return 1 when a result is due
    function automatic bit proof_step(input mkv_pkg::in_item_t it,
                                      output mkv_pkg::out_item_t res);
        logic [255:0] h;
        h   = {it.hash_word0, it.hash_word1, it.hash_word2, it.hash_word3};
        res = '0;
        if (it.req_type == mkv_pkg::REQ_START)
        begin
            proof.acc  = h;
            proof.idx  = it.position;
            proof.open = 1'b1;
            if (it.leaf_count == 0 || it.position >= it.leaf_count)
            begin
                proof.fault = mkv_pkg::ST_BAD_IDX;
                proof.last  = '0;
            end
            else
            begin
                proof.fault = mkv_pkg::ST_OK;
                proof.last  = it.leaf_count - 64'd1;
            end
        end
        else
        begin
            if (!proof.open)
            begin
                res.status = mkv_pkg::ST_NO_START;
                return 1'b1;
            end
            if (proof.fault == mkv_pkg::ST_OK)
            begin
                if (proof.last == 0)
                    proof.fault = mkv_pkg::ST_BAD_LEN;
                else if (proof.idx[0] || proof.idx == proof.last)
                begin
                    proof.acc = interior_node(h, proof.acc);
                    // skip the levels where this node is a lone left child
                    while (!proof.idx[0] && proof.idx != 0)
                    begin
                        proof.idx  = proof.idx >> 1;
                        proof.last = proof.last >> 1;
                    end
                    proof.idx  = proof.idx >> 1;
                    proof.last = proof.last >> 1;
                end
                else
                begin
                    proof.acc  = interior_node(proof.acc, h);
                    proof.idx  = proof.idx >> 1;
                    proof.last = proof.last >> 1;
                end
            end
        end
        if (!it.final_item)
            return 1'b0;
        if (proof.fault != mkv_pkg::ST_OK)
            res.status = proof.fault;
        else if (proof.last != 0)
            res.status = mkv_pkg::ST_BAD_LEN;
        else if (proof.acc != root_reg)
            res.status = mkv_pkg::ST_MISMATCH;
        else
            res.status = mkv_pkg::ST_OK;
        {res.built_word0, res.built_word1, res.built_word2, res.built_word3} = proof.acc;
        proof.open = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [255:0] rand256();
        return {rand64(), rand64(), rand64(), rand64()};
    endfunction

    function automatic mkv_pkg::in_item_t make_item(input logic kind, input logic [255:0] h,
                                                    input logic [63:0] pos,
                                                    input logic [63:0] cnt,
                                                    input logic fin);
        mkv_pkg::in_item_t it;
        it.req_type = kind;
        {it.hash_word0, it.hash_word1, it.hash_word2, it.hash_word3} = h;
        it.position   = pos;
        it.leaf_count = cnt;
        it.final_item = fin;
        return it;
    endfunction

    // Send one transaction; record the predicted result at acceptance
    task automatic send_item(input mkv_pkg::in_item_t it, input bit typed,
                             input mkv_pkg::out_item_t typed_res);
        mkv_pkg::out_item_t res;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (proof_step(it, res))
            pending_results = {pending_results, (typed ? typed_res : res)};
    endtask

    // Hold off until every result is back and the block has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            mkv_pkg::CFG_ROOT0: root_reg[255:192] = value;
            mkv_pkg::CFG_ROOT1: root_reg[191:128] = value;
            mkv_pkg::CFG_ROOT2: root_reg[127:64]  = value;
            default:            root_reg[63:0]    = value;
        endcase
        @(posedge clk);
    endtask

    task automatic set_root(input logic [255:0] r);
        write_cfg(mkv_pkg::CFG_ROOT0, r[255:192]);
        write_cfg(mkv_pkg::CFG_ROOT1, r[191:128]);
        write_cfg(mkv_pkg::CFG_ROOT2, r[127:64]);
        write_cfg(mkv_pkg::CFG_ROOT3, r[63:0]);
    endtask

    // Build a well-formed path; optionally break its length. Returns the rebuilt root.
    task automatic build_proof(output mkv_pkg::in_item_t seq[$], output logic [255:0] built);
        proof_state_t       saved;
        mkv_pkg::out_item_t dummy;
        mkv_pkg::in_item_t  it;
        logic [63:0]        cnt, pos;
        int                 sel;
        saved = proof;
        seq.delete();
        if ($urandom_range(0, 19) == 0)
        begin
            cnt = rand64();
            if (cnt == 0)
                cnt = 1;
            pos = rand64() % cnt;
        end
        else
        begin
            cnt = 64'($urandom_range(1, 40));
            pos = 64'($urandom_range(0, 39)) % cnt;
        end
        it = make_item(mkv_pkg::REQ_START, rand256(), pos, cnt, 1'b0);
        void'(proof_step(it, dummy));
        seq = {seq, it};
        while (proof.last != 0 && proof.fault == mkv_pkg::ST_OK)
        begin
            it = make_item(mkv_pkg::REQ_SIBLING, rand256(), rand64(), rand64(), 1'b0);
            void'(proof_step(it, dummy));
            seq = {seq, it};
        end
        built = proof.acc;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            seq = {seq, make_item(mkv_pkg::REQ_SIBLING, rand256(), rand64(), rand64(), 1'b0)};
        else if (sel == 1 && seq.size() > 1)
            void'(seq.pop_back());
        seq[seq.size() - 1].final_item = 1'b1;
        proof = saved;
    endtask

    // Check results in order
    always @(posedge clk)
    begin
        mkv_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: status %0d", out_data.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.status !== out_data.status
                    || want.built_word0 !== out_data.built_word0
                    || want.built_word1 !== out_data.built_word1
                    || want.built_word2 !== out_data.built_word2
                    || want.built_word3 !== out_data.built_word3)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("result mismatch: expected %0d %h_%h_%h_%h got %0d %h_%h_%h_%h",
                                 want.status, want.built_word0, want.built_word1,
                                 want.built_word2, want.built_word3, out_data.status,
                                 out_data.built_word0, out_data.built_word1,
                                 out_data.built_word2, out_data.built_word3);
                end
            end
        end
    end

    // Stall the receiver at random
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    // Main sequence
    initial
    begin
        stim_row_t         rows[$];
        stim_row_t         row;
        mkv_pkg::in_item_t seq[$];
        logic [255:0]      ones, built;
        int                kind;
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = mkv_pkg::CFG_ROOT0;
        cfg_data    = '0;
        root_reg    = '0;
        proof       = '{acc: '0, idx: '0, last: '0, open: 1'b0, fault: mkv_pkg::ST_OK};
        error_count = 0;
        items_sent  = 0;
        calm        = 1'b0;
        ones        = '1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: stray sibling, bad sizes, size one, wrong lengths, restart
        row.typed = 1'b1;
        row.item = make_item(mkv_pkg::REQ_SIBLING, ones, '1, '1, 1'b1);
        row.result = '{mkv_pkg::ST_NO_START, '0, '0, '0, '0};
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_START, ones, '0, '0, 1'b1);
        row.result = '{mkv_pkg::ST_BAD_IDX, '1, '1, '1, '1};
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_START, ones, '1, '1, 1'b1);
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_START, '0, '0, 64'd1, 1'b1);
        row.result = '{mkv_pkg::ST_OK, '0, '0, '0, '0};
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_START, ones, '0, 64'd1, 1'b1);
        row.result = '{mkv_pkg::ST_MISMATCH, '1, '1, '1, '1};
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_START, ones, '0, 64'd1, 1'b0);
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_SIBLING, '0, '0, '0, 1'b1);
        row.result = '{mkv_pkg::ST_BAD_LEN, '1, '1, '1, '1};
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_START, '0, '0, 64'd2, 1'b1);
        row.result = '{mkv_pkg::ST_BAD_LEN, '0, '0, '0, '0};
        rows = {rows, row};
        row.typed = 1'b0;
        row.item = make_item(mkv_pkg::REQ_START, 256'h1234, 64'd6, 64'd7, 1'b0);
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_SIBLING, ones, '0, '0, 1'b0);
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_SIBLING, 256'h55, '0, '0, 1'b1);
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_START, 256'h77, 64'd4, 64'd7, 1'b0);
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_SIBLING, 256'h99, '0, '0, 1'b0);
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_START, 256'haa, 64'd3, 64'd8, 1'b0);
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_SIBLING, 256'hbb, '0, '0, 1'b0);
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_SIBLING, 256'hcc, '0, '0, 1'b0);
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_SIBLING, 256'hdd, '0, '0, 1'b1);
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_START, 256'h1, 64'd9, 64'd5, 1'b0);
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_SIBLING, 256'h2, '0, '0, 1'b1);
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_START, 256'h3, 64'hffff_ffff_ffff_fffe, '1, 1'b0);
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_SIBLING, 256'h4, '0, '0, 1'b0);
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_SIBLING, 256'h5, '0, '0, 1'b1);
        rows = {rows, row};
        row.item = make_item(mkv_pkg::REQ_SIBLING, 256'h6, '0, '0, 1'b0);
        rows = {rows, row};
        foreach (rows[i])
            send_item(rows[i].item, rows[i].typed, rows[i].result);
        drain();

        // Root register extremes
        set_root(ones);
        send_item(make_item(mkv_pkg::REQ_START, ones, '1, '0, 1'b0), 1'b0, '0);
        send_item(make_item(mkv_pkg::REQ_START, ones, '0, 64'd1, 1'b1), 1'b0, '0);
        drain();
        set_root(rand256());

        // Random proofs: mostly well-formed, some against their own root, some noise
        while (items_sent < 1200)
        begin
            calm = (items_sent >= 450 && items_sent < 600);
            kind = $urandom_range(0, 99);
            if (kind < 75)
            begin
                build_proof(seq, built);
                if (kind < 45)
                begin
                    drain();
                    set_root(built);
                end
                foreach (seq[i])
                    send_item(seq[i], 1'b0, '0);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_item(make_item(1'($urandom_range(0, 1)), rand256(),
                                        ($urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 9))),
                                        ($urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 9))),
                                        1'($urandom_range(0, 1))), 1'b0, '0);
            end
        end
        drain();

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Timeout
    initial
    begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
